>>> design/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg: shared definitions for the multi-stack shared array unit
// Widths, status and register codes, defaults and the controller command.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int DEF_MAX_STACKS = 8;
  localparam int DEF_MEM_DEPTH  = 128;

  localparam int VALUE_W  = 32;
  localparam int NUM_W    = 4;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Word addresses are at most 14 * 255 + 255, and the memory depth can be
  // 4096, so 13 bits hold every address and the depth itself.
  localparam int ADDR_W = 13;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b1;

  localparam logic [NUM_W-1:0]   STACK_COUNT_RST = 4'd1;
  localparam logic [COUNT_W-1:0] REGION_SIZE_RST = 8'd16;

  localparam logic [VALUE_W-1:0] EMPTY_SENTINEL = 32'd404;

  typedef struct packed {
    logic load_item;  // capture the accepted item and its region base
    logic exec;       // check, update fill count, write or read memory
    logic load_out;   // move the answer into the output register
  } msa_cmd_t;

endpackage

>>> design/msa_if.sv
// ----------------------------------------------------------------------------
// msa_req_if / msa_rsp_if: item channels of the multi-stack unit
// Valid/ready channels carrying one request or one response item.
// ----------------------------------------------------------------------------
interface msa_req_if import msa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [NUM_W-1:0]           stack_number;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, output operation, output stack_number,
                  output push_value, input ready);
  modport sink   (input valid, input operation, input stack_number,
                  input push_value, output ready);
endinterface

interface msa_rsp_if import msa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  pop_value;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

>>> design/msa_ctrl.sv
// ----------------------------------------------------------------------------
// msa_ctrl: sequencing controller
// Accepts one item, runs it through execute and output load, owns out valid.
// ----------------------------------------------------------------------------
module msa_ctrl import msa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output msa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.exec      = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/msa_dp.sv
// ----------------------------------------------------------------------------
// msa_dp: datapath of the multi-stack unit
// Configuration registers, fill counts, shared word memory and result regs.
// ----------------------------------------------------------------------------
module msa_dp import msa_pkg::*; #(
  parameter int MAX_STACKS = DEF_MAX_STACKS,
  parameter int MEM_DEPTH  = DEF_MEM_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  msa_cmd_t                   cmd,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       operation,
  input  logic [NUM_W-1:0]           stack_number,
  input  logic signed [VALUE_W-1:0]  push_value,
  output logic signed [VALUE_W-1:0]  pop_value,
  output logic [STATUS_W-1:0]        status
);

  // Stack numbers are four bits, so at most fifteen stacks can be named.
  localparam int NUM_FILL = (MAX_STACKS < 15) ? MAX_STACKS : 15;
  localparam int FILL_IW  = (NUM_FILL > 1) ? $clog2(NUM_FILL) : 1;
  localparam int MEM_AW   = $clog2(MEM_DEPTH);
  localparam logic [6:0]        MAX_STACKS_V = 7'(MAX_STACKS);
  localparam logic [ADDR_W-1:0] MEM_DEPTH_V  = ADDR_W'(MEM_DEPTH);

  logic [NUM_W-1:0]   stack_count;
  logic [COUNT_W-1:0] region_size;
  logic [COUNT_W-1:0] fill_count [NUM_FILL];

  logic                op_q;
  logic [NUM_W-1:0]    num_q;
  logic [VALUE_W-1:0]  val_q;
  logic [ADDR_W-1:0]   base_q;

  logic [VALUE_W-1:0]  mem [MEM_DEPTH];
  logic [VALUE_W-1:0]  rd_data;
  logic [VALUE_W-1:0]  value_q;
  logic [STATUS_W-1:0] status_q;
  logic                use_mem_q;

  logic [NUM_W-1:0]    num_m1_in;
  logic [NUM_W-1:0]    idx;
  logic [FILL_IW-1:0]  fidx;
  logic                bad;
  logic [COUNT_W-1:0]  fill;
  logic [ADDR_W-1:0]   push_addr;
  logic [ADDR_W-1:0]   pop_addr;
  logic                push_ok;
  logic                pop_ok;
  logic                pop_in_mem;
  logic [STATUS_W-1:0] status_calc;
  logic [VALUE_W-1:0]  value_calc;

  assign num_m1_in = stack_number - 4'd1;

  // Item checks, evaluated in the execute cycle on the captured item.
  assign idx  = num_q - 4'd1;
  assign fidx = idx[FILL_IW-1:0];
  assign bad  = (num_q == '0) || (num_q > stack_count) || (7'(num_q) > MAX_STACKS_V);
  assign fill = bad ? '0 : fill_count[fidx];

  assign push_addr  = base_q + ADDR_W'(fill);
  assign pop_addr   = base_q + ADDR_W'(fill) - ADDR_W'(1);
  assign push_ok    = !bad && (op_q == OP_PUSH) && (fill < region_size)
                      && (push_addr < MEM_DEPTH_V);
  assign pop_ok     = !bad && (op_q == OP_POP) && (fill != '0);
  assign pop_in_mem = pop_ok && (pop_addr < MEM_DEPTH_V);

  always_comb begin
    value_calc = '0;
    if (bad) begin
      status_calc = ST_BAD;
    end else if (op_q == OP_PUSH) begin
      status_calc = push_ok ? ST_OK : ST_FULL;
    end else if (pop_ok) begin
      status_calc = ST_OK;
    end else begin
      status_calc = ST_EMPTY;
      value_calc  = EMPTY_SENTINEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= STACK_COUNT_RST;
      region_size <= REGION_SIZE_RST;
      for (int i = 0; i < NUM_FILL; i++) begin
        fill_count[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_STACK_COUNT: stack_count <= cfg_data[NUM_W-1:0];
          CFG_REGION_SIZE: region_size <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec && push_ok) begin
        fill_count[fidx] <= fill + 8'd1;
      end else if (cmd.exec && pop_ok) begin
        fill_count[fidx] <= fill - 8'd1;
      end
    end
  end

  // Item capture; the region base multiply is registered here.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= operation;
      num_q  <= stack_number;
      val_q  <= push_value;
      base_q <= ADDR_W'(num_m1_in) * ADDR_W'(region_size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[push_addr[MEM_AW-1:0]] <= val_q;
    end
    if (cmd.exec && pop_in_mem) begin
      rd_data <= mem[pop_addr[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      value_q   <= value_calc;
      status_q  <= status_calc;
      use_mem_q <= pop_in_mem;
    end
    if (cmd.load_out) begin
      pop_value <= use_mem_q ? rd_data : value_q;
      status    <= status_q;
    end
  end

endmodule

>>> design/multi_stack_shared_array_unit.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_array_unit: several LIFO stacks in one word memory
// Each request item names a stack, numbered from 1, and pushes or pops one
// 32-bit word. Stack k owns the fixed region that starts at word
// (k-1)*region_size. Every item gives exactly one response item: status ok,
// full (region or memory exhausted), empty (pop value 404) or bad stack
// number. The accepting edge captures the item and forms its region base
// with a small multiply. In the next cycle the item is checked, its fill
// count is updated and the single-port memory is accessed. Then, once the
// output register is free, the answer moves into it and the response is
// offered. The request side is ready again in that same cycle, so a new
// item is accepted only after the last answer has moved out. A held
// response stalls the next item only in its output load step. Configuration
// writes (register 0 stack count, register 1 region size) are taken at any
// edge with cfg_write high and must only be issued while the unit is idle.
// ----------------------------------------------------------------------------
module multi_stack_shared_array_unit import msa_pkg::*; #(
  parameter int MAX_STACKS = DEF_MAX_STACKS,
  parameter int MEM_DEPTH  = DEF_MEM_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msa_req_if.sink               req,
  msa_rsp_if.source             rsp
);

  msa_cmd_t cmd;

  // The controller sequences each item and owns both handshakes.
  msa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the registers, fill counts, memory and result.
  msa_dp #(
    .MAX_STACKS (MAX_STACKS),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (req.operation),
    .stack_number (req.stack_number),
    .push_value   (req.push_value),
    .pop_value    (rsp.pop_value),
    .status       (rsp.status)
  );

endmodule

>>> sim/tb_multi_stack_shared_array_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_stack_shared_array_unit: self-checking bench for the stack unit
// Drives push and pop items into the unit and keeps its own copy of the fill
// counts, the shared word memory and both registers. Every response is
// compared in order against the predicted answer. Directed tests cover the
// corner cases; random phases walk through several register settings.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_array_unit;
  import msa_pkg::*;

  localparam int NUM_STACKS = DEF_MAX_STACKS;
  localparam int MEM_WORDS  = DEF_MEM_DEPTH;
  localparam int TIMEOUT_NS = 400_000;

  // One expected response item.
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } stack_answer_t;

  logic clk;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  msa_req_if req_ch ();
  msa_rsp_if rsp_ch ();

  multi_stack_shared_array_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the unit: registers, per-stack fill counts and memory.
  // word_written keeps track of which memory words hold data, so that the
  // stimulus never pops a word that was never pushed.
  logic [NUM_W-1:0]   cfg_stacks;
  logic [COUNT_W-1:0] cfg_region;
  logic [COUNT_W-1:0] fill_words [NUM_STACKS];
  logic [VALUE_W-1:0] stack_mem [MEM_WORDS];
  bit                 word_written [MEM_WORDS];

  // Answers waiting for their response item, oldest first.
  stack_answer_t answers_due[$];

  int mismatch_count;
  int items_sent;
  int results_seen;
  int settings_used;
  int status_tally [4];

  // Pacing controls shared between the test tasks and the two drivers.
  bit req_idle;
  bit rsp_idle;
  int rsp_hold_cycles;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time in case the unit hangs.
  initial begin
    #TIMEOUT_NS;
    $display("TIMEOUT: %0d of %0d responses received", results_seen, items_sent);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    // Keep the log readable when the design is badly broken.
    if (mismatch_count < 40) $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  // Stack count above the number of stacks the unit has acts as the maximum.
  function automatic int active_stacks();
    return (cfg_stacks > NUM_STACKS) ? NUM_STACKS : int'(cfg_stacks);
  endfunction

  // Work out the answer to one accepted item and update the shadow state.
  function automatic void predict_item(input logic op, input logic [NUM_W-1:0] num,
                                       input logic [VALUE_W-1:0] data);
    stack_answer_t ans;
    int unsigned   idx;
    int unsigned   base;
    int unsigned   fill;
    int unsigned   addr;
    ans.value = '0;
    if (num == 0 || num > active_stacks()) begin
      ans.status = ST_BAD;
    end else begin
      idx  = num - 1;
      base = idx * cfg_region;
      fill = fill_words[idx];
      if (op == OP_PUSH) begin
        addr = base + fill;
        // A push is refused when its region is full or it runs off the memory.
        if (fill >= cfg_region || addr >= MEM_WORDS) begin
          ans.status = ST_FULL;
        end else begin
          stack_mem[addr]    = data;
          word_written[addr] = 1'b1;
          fill_words[idx]    = COUNT_W'(fill + 1);
          ans.status         = ST_OK;
        end
      end else if (fill == 0) begin
        ans.value  = EMPTY_SENTINEL;
        ans.status = ST_EMPTY;
      end else begin
        // After a region change the top word may sit past the memory end;
        // it then reads as zero, still with an ok status.
        addr            = base + fill - 1;
        ans.value       = (addr < MEM_WORDS) ? stack_mem[addr] : '0;
        fill_words[idx] = COUNT_W'(fill - 1);
        ans.status      = ST_OK;
      end
    end
    status_tally[ans.status]++;
    answers_due.push_back(ans);
  endfunction

  // A pop is allowed unless it would read a memory word never pushed.
  function automatic bit pop_is_safe(input logic [NUM_W-1:0] num);
    int unsigned idx;
    int unsigned addr;
    if (num == 0 || num > active_stacks()) return 1'b1;
    idx = num - 1;
    if (fill_words[idx] == 0) return 1'b1;
    addr = idx * cfg_region + fill_words[idx] - 1;
    return (addr >= MEM_WORDS) || word_written[addr];
  endfunction

  // Offer one item and return at the edge that accepts it. Valid is left
  // high: the next call either replaces the payload in the same time step or
  // lowers valid for its gap, and drain_results lowers it at the end of a
  // phase. No time may pass between a return and one of those calls.
  task automatic send_item(input logic op, input logic [NUM_W-1:0] num,
                           input logic [VALUE_W-1:0] data);
    int gap;
    gap = req_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.stack_number <= num;
    req_ch.push_value   <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_item(op, num, data);
    items_sent++;
  endtask

  // Random item: mostly legal stack numbers, a few bad ones, and a push in
  // place of any pop that would read an unwritten word.
  task automatic send_random_item(input int pop_pct);
    int                 limit;
    logic               op;
    logic [NUM_W-1:0]   num;
    logic [VALUE_W-1:0] data;
    limit = active_stacks();
    if (limit == 0 || $urandom_range(0, 99) < 8) begin
      num = ($urandom_range(0, 3) == 0) ? '0 : NUM_W'($urandom_range(limit + 1, 15));
    end else begin
      num = NUM_W'($urandom_range(1, limit));
    end
    op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH;
    if (op == OP_POP && !pop_is_safe(num)) op = OP_PUSH;
    case ($urandom_range(0, 15))
      0:       data = 32'h8000_0000;
      1:       data = 32'h7fff_ffff;
      2:       data = 32'h0000_0000;
      3:       data = 32'hffff_ffff;
      default: data = $urandom;
    endcase
    send_item(op, num, data);
  endtask

  // Stop offering items and wait until every answer has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // Write both registers while the unit is idle. Only the low four bits of
  // the stack count write reach the register.
  task automatic set_registers(input logic [CFG_DATA_W-1:0] count_data,
                               input logic [CFG_DATA_W-1:0] size_data);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= CFG_STACK_COUNT;
    cfg_data  <= count_data;
    @(posedge clk);
    cfg_stacks = count_data[NUM_W-1:0];
    cfg_index <= CFG_REGION_SIZE;
    cfg_data  <= size_data;
    @(posedge clk);
    cfg_region = size_data;
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Response side: when rsp_idle is set, draws a stall before each item, or
  // holds off for a long stretch when a test asks for it.
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = rsp_idle ? $urandom_range(0, 10) : 0;
      if (rsp_hold_cycles > 0) begin
        gap             = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
    end
  end

  // Response checker: every accepted response must match the oldest answer.
  always @(posedge clk) begin
    stack_answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("response %0d with nothing expected (value %h status %0d)",
                                  results_seen, rsp_ch.pop_value, rsp_ch.status));
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.pop_value !== want.value)
          report_mismatch($sformatf("response %0d: pop_value %h, wanted %h",
                                    results_seen, rsp_ch.pop_value, want.value));
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("response %0d: status %0d, wanted %0d",
                                    results_seen, rsp_ch.status, want.status));
      end
      results_seen++;
    end
  end

  // Plain LIFO order at the reset settings: one stack of sixteen words.
  // Covers the empty pop, the value extremes and every kind of bad number.
  task automatic test_basic_lifo();
    req_idle = 1'b0;
    rsp_idle = 1'b0;
    send_item(OP_POP,  4'd1,  32'h1234_5678);
    send_item(OP_PUSH, 4'd1,  32'h8000_0000);
    send_item(OP_PUSH, 4'd1,  32'h7fff_ffff);
    send_item(OP_PUSH, 4'd1,  32'h0f0f_a5a5);
    send_item(OP_POP,  4'd1,  32'hffff_ffff);
    send_item(OP_POP,  4'd1,  32'h0000_0000);
    send_item(OP_POP,  4'd1,  32'hdead_beef);
    send_item(OP_POP,  4'd1,  32'h0000_0000);
    send_item(OP_PUSH, 4'd0,  32'h5555_5555);
    send_item(OP_POP,  4'd2,  32'haaaa_aaaa);
    send_item(OP_PUSH, 4'd15, 32'hffff_ffff);
  endtask

  // Two-word regions: fill stack 8 past its end, then widen the regions while
  // data is held so that old tops land past the memory end.
  task automatic test_region_change();
    set_registers(8'd8, 8'd2);
    req_idle = 1'b1;
    rsp_idle = 1'b1;
    send_item(OP_PUSH, 4'd8, 32'h0000_0a0a);
    send_item(OP_PUSH, 4'd8, 32'h0000_0b0b);
    send_item(OP_PUSH, 4'd8, 32'h0000_0c0c);
    send_item(OP_PUSH, 4'd2, 32'hc001_d00d);
    send_item(OP_PUSH, 4'd2, 32'hfeed_f00d);
    send_item(OP_PUSH, 4'd1, 32'h1357_9bdf);
    send_item(OP_POP,  4'd8, 32'h0000_0000);
    // Stack 2 now starts at word 255, so both of its words read as zero.
    set_registers(8'd8, 8'd255);
    send_item(OP_POP,  4'd2, 32'h0000_0000);
    send_item(OP_POP,  4'd2, 32'hffff_ffff);
    send_item(OP_POP,  4'd1, 32'h0000_0000);
  endtask

  // Register extremes: a stack count of zero, a region size of zero, and a
  // stack count above the stacks the unit has. The write data carries bits
  // above the stack count field, which the unit drops.
  task automatic test_register_extremes();
    set_registers(8'hf0, 8'd9);
    send_item(OP_PUSH, 4'd1, 32'h0000_0001);
    set_registers(8'h0f, 8'd0);
    send_item(OP_PUSH, 4'd3, 32'h0000_0002);
    send_item(OP_POP,  4'd3, 32'h0000_0003);
    send_item(OP_PUSH, 4'd9, 32'h0000_0004);
    send_item(OP_PUSH, 4'd8, 32'h0000_0005);
  endtask

  // The response side holds off for a long stretch while items keep coming,
  // so the unit fills up and has to stall its request side.
  task automatic test_output_stall();
    int i;
    set_registers(8'd8, 8'd16);
    req_idle        = 1'b0;
    rsp_idle        = 1'b0;
    rsp_hold_cycles = 80;
    for (i = 0; i < 16; i++) send_random_item(30);
  endtask

  // One random phase: fill and drain bursts alternate so that both full and
  // empty stacks come up often.
  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] count_data,
                                  input logic [CFG_DATA_W-1:0] size_data, input int n_items);
    int i;
    int pop_pct;
    set_registers(count_data, size_data);
    req_idle = ($urandom_range(0, 3) != 0);
    rsp_idle = ($urandom_range(0, 3) != 0);
    pop_pct  = 80;
    for (i = 0; i < n_items; i++) begin
      if (i % 24 == 0) pop_pct = 100 - pop_pct;
      send_random_item(pop_pct);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(8'd8,  8'd16,  120);
    run_random_phase(8'd8,  8'd128, 80);   // stacks 2 to 8 start past the memory
    run_random_phase(8'haf, 8'd1,   60);   // count of 15 acts as 8
    run_random_phase(8'h50, 8'd9,   20);   // count of 0: every number is bad
    run_random_phase(8'd3,  8'd255, 60);
    run_random_phase(8'd8,  8'd0,   40);
    run_random_phase(8'd5,  8'd7,   120);
    run_random_phase(8'd1,  8'd128, 100);  // one stack spanning the whole memory
    run_random_phase(8'd8,  8'd16,  100);
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= CFG_STACK_COUNT;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_PUSH;
    req_ch.stack_number <= '0;
    req_ch.push_value   <= '0;
    cfg_stacks      = STACK_COUNT_RST;
    cfg_region      = REGION_SIZE_RST;
    rsp_hold_cycles = 0;
    req_idle        = 1'b0;
    rsp_idle        = 1'b0;
    for (int s = 0; s < NUM_STACKS; s++) fill_words[s] = '0;
    for (int w = 0; w < MEM_WORDS; w++) word_written[w] = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_lifo();
    test_region_change();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();

    // Let everything come back, then give a stray extra response time to show.
    drain_results();
    repeat (12) @(posedge clk);

    $display("Run covered %0d items and %0d responses over %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Answers: %0d ok, %0d full, %0d empty, %0d bad stack number.",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_BAD]);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/msa_pkg.sv
design/msa_if.sv
design/msa_ctrl.sv
design/msa_dp.sv
design/multi_stack_shared_array_unit.sv
sim/tb_multi_stack_shared_array_unit.sv
